FILE: rtl/core/pftc_pkg.sv
`timescale 1ns / 1ps

package pftc_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int KEY_BITS_DEF = 48;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 48;
  localparam int CC_W     = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;
  localparam int CAP_W    = 7;
  localparam int STAMP_W  = 32;
  localparam int USERS_W  = 8;

  localparam logic [CAP_W-1:0]   CAP_RESET = 7'd32;
  localparam logic [USERS_W-1:0] USERS_MAX = 8'hFF;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    SCAN_FREE         = 2'd0,
    SCAN_PIN_MATCH    = 2'd1,
    SCAN_UNPIN_MATCH  = 2'd2,
    SCAN_OLDEST_UNPIN = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [CC_W-1:0]     client_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                evicted;
    logic [KEY_W-1:0]    evicted_key;
  } rsp_t;

  typedef struct packed {
    logic       start;
    scan_mode_t mode;
  } scan_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

FILE: rtl/core/pftc_store.sv
`timescale 1ns / 1ps

module pftc_store #(
  parameter int DEPTH = pftc_pkg::SLOTS_DEF,
  parameter int WIDTH = 90
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/pftc_scan.sv
`timescale 1ns / 1ps

module pftc_scan #(
  parameter int SLOTS    = pftc_pkg::SLOTS_DEF,
  parameter int KEY_BITS = pftc_pkg::KEY_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  pftc_pkg::scan_cmd_t                                    cmd,
  input  logic [KEY_BITS-1:0]                                    key,
  input  logic [pftc_pkg::STAMP_W-1:0]                           stamp_now,
  output logic                                                   rd_en,
  output logic [$clog2(SLOTS)-1:0]                               rd_addr,
  input  logic [2+KEY_BITS+pftc_pkg::USERS_W+pftc_pkg::STAMP_W-1:0] rd_data,
  output pftc_pkg::scan_stat_t                                   stat,
  output logic [$clog2(SLOTS)-1:0]                               best_idx,
  output logic [2+KEY_BITS+pftc_pkg::USERS_W+pftc_pkg::STAMP_W-1:0] best_row
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int KEY_LSB = pftc_pkg::STAMP_W + pftc_pkg::USERS_W;
  localparam int PIN_BIT = KEY_LSB + KEY_BITS;
  localparam int VLD_BIT = PIN_BIT + 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  logic                         issuing;
  logic [IDX_W-1:0]             addr;
  logic                         eval;
  logic                         eval_last;
  logic [IDX_W-1:0]             eval_idx;
  logic                         done;
  logic                         found;
  pftc_pkg::scan_mode_t         mode;
  logic [pftc_pkg::STAMP_W-1:0] best_age;
  logic [pftc_pkg::STAMP_W-1:0] age;
  logic                         key_eq;
  logic                         row_vld;
  logic                         row_pin;
  logic                         better;

  assign rd_en   = issuing;
  assign rd_addr = addr;

  assign row_vld = rd_data[VLD_BIT];
  assign row_pin = rd_data[PIN_BIT];
  assign key_eq  = (rd_data[KEY_LSB +: KEY_BITS] == key);
  assign age     = stamp_now - rd_data[pftc_pkg::STAMP_W-1:0];

  always_comb begin
    unique case (mode)
      pftc_pkg::SCAN_FREE: begin
        better = !row_vld && !found;
      end
      pftc_pkg::SCAN_PIN_MATCH: begin
        better = row_vld && row_pin && key_eq && (!found || age > best_age);
      end
      pftc_pkg::SCAN_UNPIN_MATCH: begin
        better = row_vld && !row_pin && key_eq && (!found || age > best_age);
      end
      pftc_pkg::SCAN_OLDEST_UNPIN: begin
        better = row_vld && !row_pin && (!found || age > best_age);
      end
      default: begin
        better = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      eval      <= 1'b0;
      eval_last <= 1'b0;
      done      <= 1'b0;
      found     <= 1'b0;
      addr      <= '0;
      mode      <= pftc_pkg::SCAN_FREE;
    end else begin
      done      <= eval && eval_last;
      eval      <= issuing;
      eval_last <= issuing && (addr == LAST);
      eval_idx  <= addr;
      if (cmd.start) begin
        issuing <= 1'b1;
        addr    <= '0;
        found   <= 1'b0;
        mode    <= cmd.mode;
      end else if (issuing) begin
        addr <= addr + 1'b1;
        if (addr == LAST) begin
          issuing <= 1'b0;
        end
      end
      if (eval && better) begin
        found    <= 1'b1;
        best_idx <= eval_idx;
        best_row <= rd_data;
        best_age <= age;
      end
    end
  end

  assign stat.done  = done;
  assign stat.found = found;

endmodule

FILE: rtl/core/pinned_fifo_tile_cache.sv
`timescale 1ns / 1ps
// After reset the store is cleared one slot per cycle, every slot, before the first item.
// Each item runs zero to two scans of the store through a shared age comparator;
// a scan reads one slot from the entry memory per cycle.
// A refused insert or an undefined action goes from acceptance straight to the finish state;
// a pin runs scan A, scan B and the write state first, an eviction a scan, the write and evict states; the next item is
// taken in the cycle after the result is loaded, while that result waits to be accepted.

module pinned_fifo_tile_cache #(
  parameter int SLOTS    = pftc_pkg::SLOTS_DEF,
  parameter int KEY_BITS = pftc_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pftc_pkg::req_t             req,
  input  logic                       req_valid,
  output logic                       req_ready,
  output pftc_pkg::rsp_t             rsp,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  logic                       cfg_wr_en,
  input  logic [pftc_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CMP_W     = (CNT_W > pftc_pkg::CAP_W) ? CNT_W : pftc_pkg::CAP_W;
  localparam int USERS_LSB = pftc_pkg::STAMP_W;
  localparam int KEY_LSB   = pftc_pkg::STAMP_W + pftc_pkg::USERS_W;
  localparam int PIN_BIT   = KEY_LSB + KEY_BITS;
  localparam int ROW_W     = PIN_BIT + 2;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SCAN_A = 8'b0000_0100,
    ST_SCAN_B = 8'b0000_1000,
    ST_WRITE  = 8'b0001_0000,
    ST_EVICT  = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_SPARE  = 8'b1000_0000
  } state_t;

  state_t                        state;
  logic [IDX_W-1:0]              clr_idx;
  logic [pftc_pkg::CAP_W-1:0]    capacity;
  logic [CNT_W-1:0]              count;
  logic [pftc_pkg::STAMP_W-1:0]  order_cnt;
  logic [pftc_pkg::ACTION_W-1:0] act;
  logic [KEY_BITS-1:0]           key_q;
  logic [pftc_pkg::CC_W-1:0]     cc_q;
  logic [IDX_W-1:0]              wr_idx;
  logic [ROW_W-1:0]              wr_row;
  logic [ROW_W-1:0]              row_next;
  pftc_pkg::rsp_t                res;

  pftc_pkg::scan_cmd_t           scan_cmd;
  pftc_pkg::scan_stat_t          scan_stat;
  logic [IDX_W-1:0]              best_idx;
  logic [ROW_W-1:0]              best_row;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic [ROW_W-1:0]              rd_data;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [ROW_W-1:0]              mem_wdata;

  logic                          accept;
  logic                          full;
  logic                          over;
  logic                          rmw_act;
  logic [pftc_pkg::USERS_W-1:0]  users;
  logic [pftc_pkg::USERS_W-1:0]  users_inc;
  logic [pftc_pkg::USERS_W-1:0]  users_dec;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(SLOTS));
  assign over      = (CMP_W'(count) > CMP_W'(capacity));
  assign rmw_act   = (act == pftc_pkg::ACT_INSERT) || (act == pftc_pkg::ACT_RELEASE);
  assign users     = best_row[USERS_LSB +: pftc_pkg::USERS_W];
  assign users_inc = (users == pftc_pkg::USERS_MAX) ? users : users + 1'b1;
  assign users_dec = (users == '0) ? users : users - 1'b1;

  always_comb begin
    row_next = best_row;
    if (state == ST_SCAN_B) begin
      row_next[PIN_BIT]                        = 1'b1;
      row_next[USERS_LSB +: pftc_pkg::USERS_W] = pftc_pkg::USERS_W'(1);
      row_next[pftc_pkg::STAMP_W-1:0]          = order_cnt;
    end else if (act == pftc_pkg::ACT_INSERT) begin
      row_next = {1'b1, (cc_q != '0), key_q, cc_q, order_cnt};
    end else if (act == pftc_pkg::ACT_LOOKUP) begin
      row_next[USERS_LSB +: pftc_pkg::USERS_W] = users_inc;
    end else begin
      row_next[USERS_LSB +: pftc_pkg::USERS_W] = users_dec;
      if (users_dec == '0) begin
        row_next[PIN_BIT]               = 1'b0;
        row_next[pftc_pkg::STAMP_W-1:0] = order_cnt;
      end
    end
  end

  always_comb begin
    scan_cmd.start = 1'b0;
    scan_cmd.mode  = pftc_pkg::SCAN_FREE;
    mem_we         = 1'b0;
    mem_waddr      = wr_idx;
    mem_wdata      = wr_row;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req.action == pftc_pkg::ACT_LOOKUP || req.action == pftc_pkg::ACT_RELEASE) begin
            scan_cmd.start = 1'b1;
            scan_cmd.mode  = pftc_pkg::SCAN_PIN_MATCH;
          end else if (req.action == pftc_pkg::ACT_INSERT && !full) begin
            scan_cmd.start = 1'b1;
            scan_cmd.mode  = pftc_pkg::SCAN_FREE;
          end
        end
      end
      ST_SCAN_A: begin
        if (scan_stat.done && !scan_stat.found && act == pftc_pkg::ACT_LOOKUP) begin
          scan_cmd.start = 1'b1;
          scan_cmd.mode  = pftc_pkg::SCAN_UNPIN_MATCH;
        end
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        if (rmw_act && over) begin
          scan_cmd.start = 1'b1;
          scan_cmd.mode  = pftc_pkg::SCAN_OLDEST_UNPIN;
        end
      end
      ST_EVICT: begin
        if (scan_stat.done && scan_stat.found) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx;
          mem_wdata = {1'b0, best_row[ROW_W-2:0]};
        end
      end
      ST_SCAN_B, ST_FINISH, ST_SPARE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      capacity  <= pftc_pkg::CAP_RESET;
      count     <= '0;
      order_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      if (rsp_valid && rsp_ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            act             <= req.action;
            key_q           <= KEY_BITS'(req.key);
            cc_q            <= req.client_count;
            res.slot        <= '0;
            res.evicted     <= 1'b0;
            res.evicted_key <= '0;
            if (req.action == pftc_pkg::ACT_INSERT && full) begin
              res.status <= pftc_pkg::ST_FULL;
              state      <= ST_FINISH;
            end else if (req.action == pftc_pkg::ACT_LOOKUP ||
                         req.action == pftc_pkg::ACT_INSERT ||
                         req.action == pftc_pkg::ACT_RELEASE) begin
              res.status <= pftc_pkg::ST_MISS;
              state      <= ST_SCAN_A;
            end else begin
              res.status <= pftc_pkg::ST_MISS;
              state      <= ST_FINISH;
            end
          end
        end
        ST_SCAN_A: begin
          if (scan_stat.done) begin
            wr_idx <= best_idx;
            wr_row <= row_next;
            if (act == pftc_pkg::ACT_INSERT) begin
              order_cnt <= order_cnt + 1'b1;
              count     <= count + 1'b1;
              state     <= ST_WRITE;
            end else if (!scan_stat.found) begin
              state <= (act == pftc_pkg::ACT_LOOKUP) ? ST_SCAN_B : ST_FINISH;
            end else if (act == pftc_pkg::ACT_LOOKUP) begin
              state <= ST_WRITE;
            end else begin
              if (users_dec == '0) begin
                order_cnt <= order_cnt + 1'b1;
              end
              state <= ST_WRITE;
            end
          end
        end
        ST_SCAN_B: begin
          if (scan_stat.done) begin
            if (scan_stat.found) begin
              wr_idx    <= best_idx;
              wr_row    <= row_next;
              order_cnt <= order_cnt + 1'b1;
              state     <= ST_WRITE;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_WRITE: begin
          res.status <= pftc_pkg::ST_OK;
          res.slot   <= pftc_pkg::SLOT_W'(wr_idx);
          state      <= (rmw_act && over) ? ST_EVICT : ST_FINISH;
        end
        ST_EVICT: begin
          if (scan_stat.done) begin
            if (scan_stat.found) begin
              count           <= count - 1'b1;
              res.evicted     <= 1'b1;
              res.evicted_key <= pftc_pkg::KEY_W'(best_row[KEY_LSB +: KEY_BITS]);
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_SPARE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  pftc_scan #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cmd       (scan_cmd),
    .key       (key_q),
    .stamp_now (order_cnt),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .stat      (scan_stat),
    .best_idx  (best_idx),
    .best_row  (best_row)
  );

  pftc_store #(
    .DEPTH (SLOTS),
    .WIDTH (ROW_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

FILE: rtl/core/pftc_checker.sv
`timescale 1ns / 1ps

module pftc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input pftc_pkg::rsp_t rsp
);

  // An accepted item keeps the block busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request channel ready right after an accepted item");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response item changed or dropped");

  a_evict_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> rsp.status == pftc_pkg::ST_OK)
    else $error("eviction reported on a failed item");

  a_no_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.evicted |-> rsp.evicted_key == '0)
    else $error("evicted key nonzero without an eviction");

  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pftc_pkg::ST_OK |-> rsp.slot == '0)
    else $error("slot nonzero on a failed item");

endmodule

bind pinned_fifo_tile_cache pftc_checker u_pftc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
